### design/r10unpk_pkg.sv
// Package for the RAW10 packed pixel unpacker.
// Holds the widths, register indexes and the 10-to-8-bit pixel scale function.
// No dependencies.
`default_nettype none

package r10unpk_pkg;

  localparam int unsigned CfgW         = 14;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned PixW         = 10;
  localparam int unsigned RowCntW      = 13;
  localparam int unsigned MaxRowPixels = 8192;
  localparam int unsigned MaxRows      = 8192;

  localparam logic [CfgIdxW-1:0] CfgRowPixels   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStrideBytes = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFrameRows   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgEightBit    = 2'd3;

  // floor(v * 255 / 1023): reciprocal estimate, then one correction step
  function automatic logic [PixW-1:0] scale_to_8bit(input logic [PixW-1:0] v);
    logic [17:0] p;
    logic [18:0] est;
    logic [8:0]  q0;
    logic [18:0] prod;
    logic [18:0] r;
    p    = {v, 8'b0} - {8'b0, v};
    est  = {1'b0, p} + {11'b0, p[17:10]};
    q0   = est[18:10];
    prod = {q0, 10'b0} - {10'b0, q0};
    r    = {1'b0, p} - prod;
    return {1'b0, q0} + ((r >= 19'd1023) ? 10'd1 : 10'd0);
  endfunction

endpackage

`default_nettype wire

### design/raw10_packed_pixel_unpacker.sv
// Top level of the RAW10 packed pixel unpacker.
// Depends on r10unpk_pkg for widths, register indexes and pixel scaling.
//
//   channel | direction | handshake               | payload
//   raw     | in        | raw_valid_i/raw_stall_o | raw_byte_i
//   pix     | out       | pix_valid_o/pix_stall_i | pixel_a..d_o, row_end_o, frame_end_o
//   cfg     | in        | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// One byte per clock unless stalled; a result appears the cycle after its fifth byte.
// Byte position, group position and row count advance in the cycle a byte is taken.
// A waiting result stalls only the byte that completes the next group.
// Reset restores the register defaults and starts at row 0, column 0.
`default_nettype none

module raw10_packed_pixel_unpacker
  import r10unpk_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  input  wire logic               raw_valid_i,
  output logic                    raw_stall_o,
  input  wire logic [7:0]         raw_byte_i,
  output logic                    pix_valid_o,
  input  wire logic               pix_stall_i,
  output logic [PixW-1:0]         pixel_a_o,
  output logic [PixW-1:0]         pixel_b_o,
  output logic [PixW-1:0]         pixel_c_o,
  output logic [PixW-1:0]         pixel_d_o,
  output logic                    row_end_o,
  output logic                    frame_end_o
);

  logic [CfgW-1:0]    row_pixels_q;
  logic [CfgW-1:0]    stride_bytes_q;
  logic [CfgW-1:0]    frame_rows_q;
  logic               eight_bit_q;

  logic [7:0]         held_q [4];
  logic [2:0]         group_pos_q, group_pos_d;
  logic [CfgW-1:0]    byte_col_q, byte_col_d;
  logic [RowCntW-1:0] row_cnt_q, row_cnt_d;

  logic               pix_valid_q, pix_valid_d;
  logic [PixW-1:0]    pix_q [4];
  logic [PixW-1:0]    pix_d [4];
  logic               row_end_q, frame_end_q;

  logic [CfgW-1:0]    pixels;
  logic [11:0]        groups;
  logic [CfgW:0]      group_bytes;
  logic [CfgW:0]      stride;
  logic [CfgW-1:0]    rows;
  logic [RowCntW-1:0] last_row;
  logic               in_group;
  logic               emit;
  logic               raw_acc;
  logic               row_last;
  logic               last_row_hit;
  logic [CfgW:0]      col_inc;
  logic               row_wrap;
  logic [PixW-1:0]    raw_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pixels_q   <= CfgW'(2560);
      stride_bytes_q <= CfgW'(3200);
      frame_rows_q   <= CfgW'(1920);
      eight_bit_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRowPixels:   row_pixels_q   <= cfg_wdata_i;
        CfgStrideBytes: stride_bytes_q <= cfg_wdata_i;
        CfgFrameRows:   frame_rows_q   <= cfg_wdata_i;
        CfgEightBit:    eight_bit_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pixels      = (row_pixels_q > CfgW'(MaxRowPixels)) ? CfgW'(MaxRowPixels) : row_pixels_q;
    groups      = pixels[CfgW-1:2];
    group_bytes = {1'b0, groups, 2'b0} + {3'b0, groups};
    stride      = ({1'b0, stride_bytes_q} < group_bytes) ? group_bytes
                                                          : {1'b0, stride_bytes_q};
    if (stride == '0) begin
      stride = (CfgW+1)'(1);
    end
    if (frame_rows_q == '0) begin
      rows = CfgW'(1);
    end else if (frame_rows_q > CfgW'(MaxRows)) begin
      rows = CfgW'(MaxRows);
    end else begin
      rows = frame_rows_q;
    end
    last_row     = RowCntW'(rows - CfgW'(1));
    in_group     = {1'b0, byte_col_q} < group_bytes;
    emit         = in_group && (group_pos_q == 3'd4);
    row_last     = {1'b0, byte_col_q} == (group_bytes - (CfgW+1)'(1));
    last_row_hit = row_cnt_q >= last_row;
    col_inc      = {1'b0, byte_col_q} + (CfgW+1)'(1);
    row_wrap     = col_inc >= stride;
  end

  assign raw_stall_o = emit && pix_valid_q && pix_stall_i;
  assign raw_acc     = raw_valid_i && !raw_stall_o;

  always_comb begin
    group_pos_d = group_pos_q;
    byte_col_d  = byte_col_q;
    row_cnt_d   = row_cnt_q;
    if (raw_acc) begin
      if (in_group) begin
        group_pos_d = emit ? 3'd0 : group_pos_q + 3'd1;
      end
      byte_col_d = col_inc[CfgW-1:0];
      if (row_wrap) begin
        byte_col_d  = '0;
        group_pos_d = 3'd0;
        row_cnt_d   = last_row_hit ? '0 : row_cnt_q + RowCntW'(1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      raw_pix  = {held_q[i], raw_byte_i[2*i +: 2]};
      pix_d[i] = eight_bit_q ? scale_to_8bit(raw_pix) : raw_pix;
    end
  end

  assign pix_valid_d = (raw_acc && emit) || (pix_valid_q && pix_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_pos_q <= '0;
      byte_col_q  <= '0;
      row_cnt_q   <= '0;
      pix_valid_q <= 1'b0;
    end else begin
      group_pos_q <= group_pos_d;
      byte_col_q  <= byte_col_d;
      row_cnt_q   <= row_cnt_d;
      pix_valid_q <= pix_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw_acc && in_group && !emit) begin
      held_q[group_pos_q[1:0]] <= raw_byte_i;
    end
    if (raw_acc && emit) begin
      pix_q       <= pix_d;
      row_end_q   <= row_last;
      frame_end_q <= row_last && last_row_hit;
    end
  end

  assign pix_valid_o = pix_valid_q;
  assign pixel_a_o   = pix_q[0];
  assign pixel_b_o   = pix_q[1];
  assign pixel_c_o   = pix_q[2];
  assign pixel_d_o   = pix_q[3];
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

`ifndef NO_ASSERTIONS
  a_group_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    group_pos_q <= 3'd4)
    else $error("group position past the fifth byte");

  a_result_from_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pix_valid_q) |-> $past(raw_acc))
    else $error("result appeared without a taken byte");

  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid_q && frame_end_q) |-> row_end_q)
    else $error("frame end flagged on a group that does not end its row");
`endif

endmodule

`default_nettype wire

### test/raw10_unpack_check.sv
`timescale 1ns / 1ps
// Scoreboard for raw10_packed_pixel_unpacker: tracks register writes and accepted bytes,
// predicts each pixel group and compares it with the accepted result items.
// Depends on r10unpk_pkg for widths and register indexes.

module raw10_unpack_check
  import r10unpk_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               raw_valid_i,
  input  logic               raw_stall_i,
  input  logic [7:0]         raw_byte_i,
  input  logic               pix_valid_i,
  input  logic               pix_stall_i,
  input  logic [PixW-1:0]    pixel_a_i,
  input  logic [PixW-1:0]    pixel_b_i,
  input  logic [PixW-1:0]    pixel_c_i,
  input  logic [PixW-1:0]    pixel_d_i,
  input  logic               row_end_i,
  input  logic               frame_end_i,
  output int                 groups_waiting_o,
  output int                 fail_count_o
);

  typedef struct packed {
    logic [3:0][PixW-1:0] pix;
    logic                 row_end;
    logic                 frame_end;
  } pixel_group_t;

  pixel_group_t pending_groups[$];

  int         row_pixels;
  int         row_stride;
  int         frame_rows;
  logic       eight_bit;
  logic [7:0] held[4];
  int         grp_pos;
  int         byte_col;
  int         row_cnt;
  int         fails = 0;
  int         groups_waiting = 0;

  assign fail_count_o     = fails;
  assign groups_waiting_o = groups_waiting;

  function automatic logic [PixW-1:0] to_eight_bit(input logic [PixW-1:0] v);
    int unsigned wide;
    wide = 32'(v);
    return PixW'((wide * 255) / 1023);
  endfunction

  task automatic take_byte(input logic [7:0] b);
    int           pixels;
    int           group_bytes;
    int           stride;
    int           rows;
    int           last_row;
    int           i;
    logic [9:0]   v;
    pixel_group_t g;
    pixels      = (row_pixels > MaxRowPixels) ? MaxRowPixels : row_pixels;
    group_bytes = (pixels / 4) * 5;
    stride      = (row_stride < group_bytes) ? group_bytes : row_stride;
    if (stride == 0) stride = 1;
    rows = frame_rows;
    if (rows == 0) rows = 1;
    if (rows > MaxRows) rows = MaxRows;
    last_row = rows - 1;

    if (byte_col < group_bytes) begin
      if (grp_pos < 4) begin
        held[grp_pos[1:0]] = b;
        grp_pos++;
      end else begin
        g.row_end   = (byte_col == group_bytes - 1);
        g.frame_end = g.row_end && (row_cnt >= last_row);
        for (i = 0; i < 4; i++) begin
          v = {held[i], b[2*i +: 2]};
          g.pix[i] = eight_bit ? to_eight_bit(v) : v;
        end
        pending_groups.push_back(g);
        grp_pos = 0;
      end
    end

    byte_col++;
    if (byte_col >= stride) begin
      byte_col = 0;
      grp_pos  = 0;
      if (row_cnt >= last_row) row_cnt = 0;
      else row_cnt++;
    end
  endtask

  task automatic check_field(input string name, input logic [PixW-1:0] want,
                             input logic [PixW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  task automatic check_group();
    pixel_group_t want;
    if (pending_groups.size() == 0) begin
      $error("result item with no group expected");
      fails++;
    end else begin
      want = pending_groups.pop_front();
      check_field("pixel_a", want.pix[0], pixel_a_i);
      check_field("pixel_b", want.pix[1], pixel_b_i);
      check_field("pixel_c", want.pix[2], pixel_c_i);
      check_field("pixel_d", want.pix[3], pixel_d_i);
      check_field("row_end", PixW'(want.row_end), PixW'(row_end_i));
      check_field("frame_end", PixW'(want.frame_end), PixW'(frame_end_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pixels = 2560;
      row_stride = 3200;
      frame_rows = 1920;
      eight_bit  = 1'b0;
      for (int i = 0; i < 4; i++) held[i] = 8'h00;
      grp_pos  = 0;
      byte_col = 0;
      row_cnt  = 0;
      pending_groups.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgRowPixels:   row_pixels = int'(cfg_wdata_i);
          CfgStrideBytes: row_stride = int'(cfg_wdata_i);
          CfgFrameRows:   frame_rows = int'(cfg_wdata_i);
          CfgEightBit:    eight_bit  = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (raw_valid_i && !raw_stall_i) take_byte(raw_byte_i);
      if (pix_valid_i && !pix_stall_i) check_group();
    end
    groups_waiting = pending_groups.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Testbench top for raw10_packed_pixel_unpacker: drives register writes and the byte
// stream with random gaps and output stalls; raw10_unpack_check predicts and compares.

module tb;
  import r10unpk_pkg::*;

  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 4;
  localparam int RandomItems = 500;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CfgRowPixels;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               raw_valid_i = 1'b0;
  logic [7:0]         raw_byte_i = 8'h00;
  logic               pix_stall_i = 1'b0;
  logic               raw_stall_o;
  logic               pix_valid_o;
  logic [PixW-1:0]    pixel_a_o;
  logic [PixW-1:0]    pixel_b_o;
  logic [PixW-1:0]    pixel_c_o;
  logic [PixW-1:0]    pixel_d_o;
  logic               row_end_o;
  logic               frame_end_o;
  int                 groups_waiting;
  int                 fail_count;

  int burst_left = 0;
  int stall_left = 0;
  int stall_pct  = 0;
  int cycle_count;

  always #1 clk_i = ~clk_i;

  raw10_packed_pixel_unpacker dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .raw_valid_i, .raw_stall_o, .raw_byte_i,
    .pix_valid_o, .pix_stall_i,
    .pixel_a_o, .pixel_b_o, .pixel_c_o, .pixel_d_o, .row_end_o, .frame_end_o
  );

  raw10_unpack_check u_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .raw_valid_i, .raw_stall_i(raw_stall_o), .raw_byte_i,
    .pix_valid_i(pix_valid_o), .pix_stall_i,
    .pixel_a_i(pixel_a_o), .pixel_b_i(pixel_b_o),
    .pixel_c_i(pixel_c_o), .pixel_d_i(pixel_d_o),
    .row_end_i(row_end_o), .frame_end_i(frame_end_o),
    .groups_waiting_o(groups_waiting), .fail_count_o(fail_count)
  );

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 90;
      endcase
    end
    stall_left--;
    pix_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CfgW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input int px, input int stride, input int rows, input int eight);
    write_reg(CfgRowPixels, px);
    write_reg(CfgStrideBytes, stride);
    write_reg(CfgFrameRows, rows);
    write_reg(CfgEightBit, eight);
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        raw_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    raw_valid_i <= 1'b1;
    raw_byte_i  <= b;
    do @(posedge clk_i); while (raw_stall_o);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  // hold until every predicted group has come out, then let the pipe go quiet
  task automatic drain();
    raw_valid_i <= 1'b0;
    @(posedge clk_i);
    while (groups_waiting != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // one padding byte with a one-byte stride puts the stream at row 0, column 0
  task automatic restart_row();
    set_geometry(0, 1, 1, 0);
    send_random(1);
    drain();
  endtask

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int n;
    int px;
    int gb;
    int stride;
    int rows;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-scale and zero groups, padding, then 8-bit scaling and frame end
    set_geometry(8, 12, 2, 0);
    repeat (5) send_byte(8'hFF);
    repeat (5) send_byte(8'h00);
    send_byte(8'hA5);
    send_byte(8'h5A);
    drain();
    write_reg(CfgEightBit, 1);
    repeat (5) send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h40);
    send_byte(8'h20);
    send_byte(8'h01);
    send_byte(8'hE4);
    send_random(2);
    drain();

    // narrow row with zero stride and zero frame rows: padding only
    set_geometry(3, 0, 0, 0);
    send_random(3);
    drain();

    // stride shorter than the group bytes
    restart_row();
    set_geometry(8, 5, 3, 1);
    send_random(10);
    drain();

    // shrink the row while the column sits past the new stride
    restart_row();
    set_geometry(12, 16, 4, 0);
    send_random(7);
    drain();
    set_geometry(4, 6, 4, 0);
    send_random(7);
    drain();

    // row count left beyond a lowered frame size
    restart_row();
    set_geometry(4, 5, 8, 0);
    send_random(25);
    drain();
    write_reg(CfgFrameRows, 3);
    send_random(5);
    drain();

    // frame rows above the maximum: walk to the last row on padding-only rows
    restart_row();
    set_geometry(2, 1, 16383, 0);
    send_random(MaxRows - 1);
    drain();
    write_reg(CfgRowPixels, 4);
    write_reg(CfgStrideBytes, 5);
    send_random(5);
    drain();

    // widest row with the largest stride register
    restart_row();
    set_geometry(16383, 16383, 2, $urandom_range(0, 1));
    send_random((MaxRowPixels / 4) * 5);
    drain();

    sent = 0;
    while (sent < RandomItems) begin
      if ($urandom_range(0, 3) != 0) restart_row();
      case ($urandom_range(0, 9))
        0: px = $urandom_range(0, 3);
        1: px = $urandom_range(MaxRowPixels + 1, 16383);
        default: px = $urandom_range(4, 40);
      endcase
      gb = (((px > MaxRowPixels) ? MaxRowPixels : px) / 4) * 5;
      if ($urandom_range(0, 4) == 0) stride = $urandom_range(0, gb);
      else stride = gb + $urandom_range(0, 7);
      if (stride > 16383) stride = 16383;
      if ($urandom_range(0, 9) == 0) rows = $urandom_range(0, 16383);
      else rows = $urandom_range(0, 4);
      set_geometry(px, stride, rows, $urandom_range(0, 1));
      n = $urandom_range(10, 60);
      send_random(n);
      sent += n;
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/r10unpk_pkg.sv
design/raw10_packed_pixel_unpacker.sv
test/raw10_unpack_check.sv
test/tb.sv
